// ----- sv/imm_pkg.sv -----
// Shared types and constants for the integer matrix multiply block.
// Used by the top level, the front end, the command queue and the back end.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

	localparam int IMM_DIM = 16;

	// At most this many result beats are produced for one compute command.
	localparam int MAX_OUT = 16;

	// Command queue between front end and back end.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Result buffer in the back end.
	localparam int OUT_DEPTH = 2;
	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] row;
		logic [3:0] col;
		logic signed [31:0] value;
	} imm_cmd_t;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		logic signed [31:0] product;
		logic last;
	} imm_res_t;

endpackage

`default_nettype wire

// ----- sv/imm_if.sv -----
// Valid/ready channel interfaces for the matrix multiply block:
// one for incoming operation beats and one for result beats. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface imm_item_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [3:0] row;
	logic [3:0] col;
	logic signed [31:0] value;

	modport source (output valid, output operation, output row, output col, output value,
		input ready);
	modport sink (input valid, input operation, input row, input col, input value,
		output ready);
endinterface

interface imm_result_if;
	logic valid;
	logic ready;
	logic [3:0] out_row;
	logic [3:0] out_col;
	logic signed [31:0] product;
	logic last;

	modport source (output valid, output out_row, output out_col, output product,
		output last, input ready);
	modport sink (input valid, input out_row, input out_col, input product, input last,
		output ready);
endinterface

`default_nettype wire

// ----- sv/integer_matrix_multiply.sv -----
// Signed 32-bit square matrix multiply with DIM by DIM stores for A and B. A load beat
// writes one element; a compute beat produces min(DIM,16) result beats for its row, each a
// dot product of DIM terms, wrapping to 32 bits. A compute occupies the back end until the
// last term of its row is issued, since every term goes through the single shared
// multiply-accumulate unit and the one read port of each store. A result beat becomes valid
// once the last term of its column has passed the store read, multiply and accumulate stages
// and been written into the result buffer; a compute beat passes through the command queue
// before the back end takes it. A four-deep command queue keeps accepting beats until full
// while a row is computed, and a two-entry result buffer lets the next column proceed while
// a result waits; with both entries taken or reserved, the next column is held until a result
// beat leaves. Reading an element that was never loaded gives an undefined value.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
	parameter int DIM = imm_pkg::IMM_DIM
) (
	input logic clk,
	input logic arst_n,
	imm_item_if.sink item,
	imm_result_if.source result
);
	import imm_pkg::*;

	logic push_valid;
	logic push_ready;
	imm_cmd_t push_cmd;
	logic cmd_valid;
	logic cmd_ready;
	imm_cmd_t cmd;

	imm_front #(.DIM(DIM)) u_front (
		.item(item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd)
	);

	imm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd),
		.pop_valid(cmd_valid),
		.pop_ready(cmd_ready),
		.pop_cmd(cmd)
	);

	imm_back #(.DIM(DIM)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.result(result)
	);

endmodule

`default_nettype wire

// ----- sv/imm_front.sv -----
// Front end: accepts operation beats, drops those that have no effect and
// forwards the rest as commands. Depends on imm_pkg and imm_if.
`timescale 1ns / 1ps
`default_nettype none

module imm_front #(
	parameter int DIM = imm_pkg::IMM_DIM
) (
	imm_item_if.sink item,
	output logic push_valid,
	input logic push_ready,
	output imm_pkg::imm_cmd_t push_cmd
);
	import imm_pkg::*;

	logic row_ok;
	logic col_ok;
	logic keep;

	assign row_ok = 32'(item.row) < DIM;
	assign col_ok = 32'(item.col) < DIM;

	// Unused codes, loads outside the matrix and computes on a missing row are dropped.
	always_comb begin
		case (item.operation)
			OP_LOAD_A, OP_LOAD_B: keep = row_ok && col_ok;
			OP_COMPUTE: keep = row_ok;
			default: keep = 1'b0;
		endcase
	end

	assign item.ready = push_ready;
	assign push_valid = item.valid && keep;

	assign push_cmd.op = item.operation;
	assign push_cmd.row = item.row;
	assign push_cmd.col = item.col;
	assign push_cmd.value = item.value;

endmodule

`default_nettype wire

// ----- sv/imm_queue.sv -----
// Small command queue that decouples the front end from the back end.
// Depends on imm_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module imm_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input imm_pkg::imm_cmd_t push_cmd,
	output logic pop_valid,
	input logic pop_ready,
	output imm_pkg::imm_cmd_t pop_cmd
);
	import imm_pkg::*;

	imm_cmd_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/imm_back.sv -----
// Back end: holds both matrix stores, runs loads and computes a result row with one
// shared multiply-accumulate pipeline, and buffers result beats. Depends on imm_pkg, imm_if.
`timescale 1ns / 1ps
`default_nettype none

module imm_back #(
	parameter int DIM = imm_pkg::IMM_DIM
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input imm_pkg::imm_cmd_t cmd,
	imm_result_if.source result
);
	import imm_pkg::*;

	localparam int EMIT = (DIM < MAX_OUT) ? DIM : MAX_OUT;
	localparam int KW = $clog2(DIM);
	localparam int CW = $clog2(EMIT);
	localparam int AW = $clog2(DIM * DIM);

	logic [31:0] store_a_q [DIM * DIM];
	logic [31:0] store_b_q [DIM * DIM];

	// Sequencer
	logic busy_q;
	logic [3:0] row_q;
	logic [CW-1:0] col_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] a_base_q;
	logic [AW-1:0] b_addr_q;
	logic [OCNT_W-1:0] credit_q;

	logic take;
	logic wr_a;
	logic wr_b;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] a_addr;
	logic issue;
	logic col_start;
	logic k_end;
	logic col_end;

	// MAC pipeline
	logic v_s1, first_s1, endk_s1, last_s1;
	logic [3:0] row_s1;
	logic [CW-1:0] col_s1;
	logic [31:0] rd_a_s1, rd_b_s1;
	logic v_s2, first_s2, endk_s2, last_s2;
	logic [3:0] row_s2;
	logic [CW-1:0] col_s2;
	logic [31:0] prod_s2;
	logic done_s3, last_s3;
	logic [3:0] row_s3;
	logic [CW-1:0] col_s3;
	logic [31:0] acc_s3;

	// Result buffer
	imm_res_t res_q [OUT_DEPTH];
	logic [OPTR_W-1:0] res_wr_q;
	logic [OPTR_W-1:0] res_rd_q;
	logic [OCNT_W-1:0] res_cnt_q;
	logic pop;
	imm_res_t head;

	assign cmd_ready = !busy_q;
	assign take = cmd_valid && !busy_q;
	assign wr_a = take && cmd.op == OP_LOAD_A;
	assign wr_b = take && cmd.op == OP_LOAD_B;
	assign wr_addr = AW'(32'(cmd.row) * DIM + 32'(cmd.col));

	assign a_addr = a_base_q + AW'(k_q);
	assign k_end = k_q == KW'(DIM - 1);
	assign col_end = col_q == CW'(EMIT - 1);
	// A column may only start when a result buffer slot is reserved for it,
	// so the pipeline never has to stall once a dot product is under way.
	assign issue = busy_q && (k_q != '0 || credit_q != '0);
	assign col_start = issue && k_q == '0;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			store_a_q[wr_addr] <= cmd.value;
		end
		if (issue) begin
			rd_a_s1 <= store_a_q[a_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			store_b_q[wr_addr] <= cmd.value;
		end
		if (issue) begin
			rd_b_s1 <= store_b_q[b_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			credit_q <= OCNT_W'(OUT_DEPTH);
		end else begin
			if (take && cmd.op == OP_COMPUTE) begin
				busy_q <= 1'b1;
			end else if (issue && k_end && col_end) begin
				busy_q <= 1'b0;
			end
			case ({col_start, pop})
				2'b10: credit_q <= credit_q - 1'b1;
				2'b01: credit_q <= credit_q + 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_q <= cmd.row;
			col_q <= '0;
			k_q <= '0;
			a_base_q <= AW'(32'(cmd.row) * DIM);
			b_addr_q <= '0;
		end else if (issue) begin
			if (k_end) begin
				k_q <= '0;
				col_q <= col_q + 1'b1;
				b_addr_q <= AW'(col_q) + 1'b1;
			end else begin
				k_q <= k_q + 1'b1;
				b_addr_q <= b_addr_q + AW'(DIM);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			done_s3 <= v_s2 && endk_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= k_q == '0;
		endk_s1 <= k_end;
		last_s1 <= col_end;
		row_s1 <= row_q;
		col_s1 <= col_q;

		prod_s2 <= rd_a_s1 * rd_b_s1;
		first_s2 <= first_s1;
		endk_s2 <= endk_s1;
		last_s2 <= last_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;

		if (v_s2) begin
			acc_s3 <= first_s2 ? prod_s2 : acc_s3 + prod_s2;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			last_s3 <= last_s2;
		end
	end

	assign pop = result.valid && result.ready;
	assign head = res_q[res_rd_q];
	assign result.valid = res_cnt_q != '0;
	assign result.out_row = head.row;
	assign result.out_col = head.col;
	assign result.product = head.product;
	assign result.last = head.last;

	always_ff @(posedge clk) begin
		if (done_s3) begin
			res_q[res_wr_q] <= '{row: row_s3, col: 4'(col_s3), product: acc_s3,
				last: last_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q <= '0;
			res_rd_q <= '0;
			res_cnt_q <= '0;
		end else begin
			if (done_s3) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			case ({done_s3, pop})
				2'b10: res_cnt_q <= res_cnt_q + 1'b1;
				2'b01: res_cnt_q <= res_cnt_q - 1'b1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= OCNT_W'(OUT_DEPTH))
		else $error("result credit count above buffer depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |-> res_cnt_q != OCNT_W'(OUT_DEPTH) || pop)
		else $error("result beat written into a full buffer");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> v_s1 && endk_s1 && last_s1)
		else $error("compute ended before the final term was issued");

	a_credit_balance: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !v_s1 && !v_s2 && !done_s3 |->
		32'(credit_q) + 32'(res_cnt_q) == OUT_DEPTH)
		else $error("credits and buffered results out of balance");
`endif

endmodule

`default_nettype wire
